/* rtl/core/modbus_rtu_frame_builder_defines.svh */
// Assertion macros for the Modbus RTU frame builder.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef MODBUS_RTU_FRAME_BUILDER_DEFINES_SVH
`define MODBUS_RTU_FRAME_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset.
`define MRFB_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Implication checked at every clock edge out of reset.
`define MRFB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`else

`define MRFB_ASSERT(label, cond, msg)
`define MRFB_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

/* rtl/core/mrfb_pkg.sv */
// Shared types, constants and the CRC-16/MODBUS byte update for the frame builder.
// No dependencies; the front, queue, back and top level refer to it by scoped names.
package mrfb_pkg;

    // Input item: one payload byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] packet_length;
        logic       last_byte;
    } t_in_item;

    // Result item: one frame byte.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       run_last;
    } t_out_item;

    // Classified payload byte handed from the front to the back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] packet_length;
        logic       header;
        logic       marker;
        logic       close;
    } t_cmd;

    // Sequencer step of the back.
    typedef logic [4:0] t_step;

    localparam t_step STEP_BC0     = 5'd0;
    localparam t_step STEP_BC1     = 5'd1;
    localparam t_step STEP_BC2     = 5'd2;
    localparam t_step STEP_BC3     = 5'd3;
    localparam t_step STEP_BC4     = 5'd4;
    localparam t_step STEP_BC5     = 5'd5;
    localparam t_step STEP_BC_CRCL = 5'd6;
    localparam t_step STEP_BC_CRCH = 5'd7;
    localparam t_step STEP_H_SLAVE = 5'd8;
    localparam t_step STEP_H_FUNC  = 5'd9;
    localparam t_step STEP_H_REGH  = 5'd10;
    localparam t_step STEP_H_REGL  = 5'd11;
    localparam t_step STEP_H_WCH   = 5'd12;
    localparam t_step STEP_H_WCL   = 5'd13;
    localparam t_step STEP_H_BCNT  = 5'd14;
    localparam t_step STEP_DATA    = 5'd15;
    localparam t_step STEP_CRCL    = 5'd16;
    localparam t_step STEP_CRCH    = 5'd17;

    // Status of the back, seen by the top level.
    typedef struct packed {
        logic  busy;
        t_step step;
    } t_back_status;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_SLAVE_ADDRESS    = 2'd0;
    localparam t_cfg_index CFG_FUNCTION_CODE    = 2'd1;
    localparam t_cfg_index CFG_REGISTER_ADDRESS = 2'd2;

    localparam logic [7:0]  SLAVE_ADDRESS_RESET    = 8'd1;
    localparam logic [7:0]  FUNCTION_CODE_RESET    = 8'd16;
    localparam logic [15:0] REGISTER_ADDRESS_RESET = 16'd0;

    // Marker bytes and the broadcast write-single-coil frame contents.
    localparam logic [7:0] MARKER_COIL33 = 8'hD2;
    localparam logic [7:0] MARKER_COIL32 = 8'hCF;
    localparam logic [7:0] BC_ADDRESS    = 8'h00;
    localparam logic [7:0] BC_FUNCTION   = 8'd5;
    localparam logic [7:0] BC_COIL_HI    = 8'h00;
    localparam logic [7:0] BC_COIL33     = 8'd33;
    localparam logic [7:0] BC_COIL32     = 8'd32;
    localparam logic [7:0] BC_VALUE_HI   = 8'hFF;
    localparam logic [7:0] BC_VALUE_LO   = 8'h00;
    localparam logic [7:0] WORD_COUNT_HI = 8'h00;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // One byte of the reflected CRC-16/MODBUS, one bit per loop pass.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/mrfb_front.sv */
// Front of the frame builder: accepts payload bytes and classifies them.
// Depends on mrfb_pkg; feeds the command queue.
module mrfb_front #(
    parameter int MAX_PACKET_BYTES = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mrfb_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_q_push,
    output mrfb_pkg::t_cmd    o_cmd
);

    localparam int PW = $clog2(MAX_PACKET_BYTES + 1);

    logic          r_inside;
    logic [PW-1:0] r_pos;
    logic          n_inside;
    logic [PW-1:0] n_pos;
    logic [PW:0]   pos_next;
    logic          accept;
    logic          header;
    logic          close;

    assign accept = i_push && !i_q_full;
    assign header = !r_inside;

    // Count the byte and decide whether it closes the packet.
    always_comb begin
        pos_next = header ? (PW + 1)'(1) : ({1'b0, r_pos} + (PW + 1)'(1));
        close    = i_item.last_byte || (pos_next >= (PW + 1)'(MAX_PACKET_BYTES));
        n_inside = r_inside;
        n_pos    = r_pos;
        if (accept) begin
            n_inside = !close;
            n_pos    = close ? '0 : pos_next[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_pos    <= '0;
        end else begin
            r_inside <= n_inside;
            r_pos    <= n_pos;
        end
    end

    // Command for the back.
    always_comb begin
        o_q_push            = accept;
        o_cmd.data_byte     = i_item.data_byte;
        o_cmd.packet_length = i_item.packet_length;
        o_cmd.header        = header;
        o_cmd.marker        = header && ((i_item.data_byte == mrfb_pkg::MARKER_COIL33) ||
                                         (i_item.data_byte == mrfb_pkg::MARKER_COIL32));
        o_cmd.close         = close;
    end

endmodule

/* rtl/core/mrfb_cmd_queue.sv */
// Two-entry command queue between the front and the back.
// Depends on mrfb_pkg for the command type.
module mrfb_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mrfb_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output mrfb_pkg::t_cmd o_cmd
);

    mrfb_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // Storage is written on every push transfer.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/core/mrfb_back.sv */
// Back of the frame builder: steps through the frame bytes of each command,
// keeps both CRCs and holds the result register. Depends on mrfb_pkg.
module mrfb_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  mrfb_pkg::t_cmd          i_q_cmd,
    output logic                    o_q_pop,
    input  logic [7:0]              i_slave_address,
    input  logic [7:0]              i_function_code,
    input  logic [15:0]             i_register_address,
    input  logic                    i_pop,
    output logic                    o_valid,
    output mrfb_pkg::t_out_item     o_result,
    output mrfb_pkg::t_back_status  o_status
);

    logic                r_busy;
    mrfb_pkg::t_step     r_step;
    mrfb_pkg::t_cmd      r_cmd;
    logic [15:0]         r_bc_crc;
    logic [15:0]         r_crc;
    logic                r_out_valid;
    mrfb_pkg::t_out_item r_out;

    logic                advance;
    logic                final_step;
    logic                finish;
    logic                load;
    logic [7:0]          cur_byte;
    logic                cur_end;
    logic [8:0]          len_plus;
    mrfb_pkg::t_step     start_step;

    assign len_plus = {1'b0, r_cmd.packet_length} + 9'd1;

    // Byte of the current step.
    always_comb begin
        cur_byte = 8'h00;
        cur_end  = 1'b0;
        unique case (r_step)
            mrfb_pkg::STEP_BC0:     cur_byte = mrfb_pkg::BC_ADDRESS;
            mrfb_pkg::STEP_BC1:     cur_byte = mrfb_pkg::BC_FUNCTION;
            mrfb_pkg::STEP_BC2:     cur_byte = mrfb_pkg::BC_COIL_HI;
            mrfb_pkg::STEP_BC3:     cur_byte = (r_cmd.data_byte == mrfb_pkg::MARKER_COIL33) ?
                                               mrfb_pkg::BC_COIL33 : mrfb_pkg::BC_COIL32;
            mrfb_pkg::STEP_BC4:     cur_byte = mrfb_pkg::BC_VALUE_HI;
            mrfb_pkg::STEP_BC5:     cur_byte = mrfb_pkg::BC_VALUE_LO;
            mrfb_pkg::STEP_BC_CRCL: cur_byte = r_bc_crc[7:0];
            mrfb_pkg::STEP_BC_CRCH: begin
                cur_byte = r_bc_crc[15:8];
                cur_end  = 1'b1;
            end
            mrfb_pkg::STEP_H_SLAVE: cur_byte = i_slave_address;
            mrfb_pkg::STEP_H_FUNC:  cur_byte = i_function_code;
            mrfb_pkg::STEP_H_REGH:  cur_byte = i_register_address[15:8];
            mrfb_pkg::STEP_H_REGL:  cur_byte = i_register_address[7:0];
            mrfb_pkg::STEP_H_WCH:   cur_byte = mrfb_pkg::WORD_COUNT_HI;
            mrfb_pkg::STEP_H_WCL:   cur_byte = len_plus[8:1];
            mrfb_pkg::STEP_H_BCNT:  cur_byte = r_cmd.packet_length;
            mrfb_pkg::STEP_DATA:    cur_byte = r_cmd.data_byte;
            mrfb_pkg::STEP_CRCL:    cur_byte = r_crc[7:0];
            mrfb_pkg::STEP_CRCH: begin
                cur_byte = r_crc[15:8];
                cur_end  = 1'b1;
            end
            default: begin
                cur_byte = 8'h00;
                cur_end  = 1'b0;
            end
        endcase
    end

    // Sequencing: one byte per cycle while the result register is free.
    always_comb begin
        advance    = r_busy && (!r_out_valid || i_pop);
        final_step = (r_step == mrfb_pkg::STEP_CRCH) ||
                     ((r_step == mrfb_pkg::STEP_DATA) && !r_cmd.close);
        finish     = advance && final_step;
        load       = i_q_valid && (!r_busy || finish);
        if (i_q_cmd.marker) begin
            start_step = mrfb_pkg::STEP_BC0;
        end else if (i_q_cmd.header) begin
            start_step = mrfb_pkg::STEP_H_SLAVE;
        end else begin
            start_step = mrfb_pkg::STEP_DATA;
        end
    end

    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= mrfb_pkg::STEP_BC0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_step <= start_step;
        end else if (finish) begin
            r_busy <= 1'b0;
        end else if (advance) begin
            r_step <= r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_q_cmd;
        end
    end

    // CRC updates: broadcast frame on its six body bytes, main frame on header and data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc_crc <= mrfb_pkg::CRC_INIT;
            r_crc    <= mrfb_pkg::CRC_INIT;
        end else if (advance) begin
            if (r_step <= mrfb_pkg::STEP_BC5) begin
                r_bc_crc <= mrfb_pkg::crc_feed((r_step == mrfb_pkg::STEP_BC0) ?
                                               mrfb_pkg::CRC_INIT : r_bc_crc, cur_byte);
            end
            if ((r_step >= mrfb_pkg::STEP_H_SLAVE) && (r_step <= mrfb_pkg::STEP_DATA)) begin
                r_crc <= mrfb_pkg::crc_feed((r_step == mrfb_pkg::STEP_H_SLAVE) ?
                                            mrfb_pkg::CRC_INIT : r_crc, cur_byte);
            end
        end
    end

    // Result register: filled on each step, emptied by a pop transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.frame_byte <= cur_byte;
            r_out.frame_end  <= cur_end;
            r_out.run_last   <= final_step;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result      = r_out;
    assign o_status.busy = r_busy;
    assign o_status.step = r_step;

endmodule

/* rtl/core/modbus_rtu_frame_builder.sv */
// Top level of the Modbus RTU write-registers frame builder.
// Depends on mrfb_pkg, mrfb_front, mrfb_cmd_queue, mrfb_back and the defines header.
//
//   Channel   Handshake                 Payload
//   input     push / full               i_item   (data_byte, packet_length, last_byte)
//   result    empty / pop               o_result (frame_byte, frame_end, run_last)
//   config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// The back sends one frame byte per clock cycle while the result register is free: a
// middle payload byte gives one frame byte, a closing byte three, a packet's first byte
// seven more (header) and a marker first byte eight more (broadcast), at most 18 bytes.
// Input bytes are taken every cycle while the two-entry command queue has room.
// Reset is synchronous; it restores the register defaults and empties queue and output.
// A stalled pop holds the result register and stops the back; the front keeps going.
`include "modbus_rtu_frame_builder_defines.svh"

module modbus_rtu_frame_builder #(
    parameter int MAX_PACKET_BYTES = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  mrfb_pkg::t_in_item   i_item,
    output logic                 empty,
    input  logic                 pop,
    output mrfb_pkg::t_out_item  o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  mrfb_pkg::t_cfg_index i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [7:0]             r_slave_address;
    logic [7:0]             r_function_code;
    logic [15:0]            r_register_address;

    logic                   q_full;
    logic                   q_push;
    mrfb_pkg::t_cmd         front_cmd;
    logic                   q_valid;
    mrfb_pkg::t_cmd         q_cmd;
    logic                   q_pop;
    logic                   out_valid;
    mrfb_pkg::t_back_status back_status;

    // Configuration registers; indexes beyond the list are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address    <= mrfb_pkg::SLAVE_ADDRESS_RESET;
            r_function_code    <= mrfb_pkg::FUNCTION_CODE_RESET;
            r_register_address <= mrfb_pkg::REGISTER_ADDRESS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mrfb_pkg::CFG_SLAVE_ADDRESS:    r_slave_address    <= i_cfg_data[7:0];
                mrfb_pkg::CFG_FUNCTION_CODE:    r_function_code    <= i_cfg_data[7:0];
                mrfb_pkg::CFG_REGISTER_ADDRESS: r_register_address <= i_cfg_data;
                default: begin
                    r_slave_address <= r_slave_address;
                end
            endcase
        end
    end

    // Front: accept and classify payload bytes.
    mrfb_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_cmd    (front_cmd)
    );

    assign full = q_full;

    // Command queue between front and back.
    mrfb_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back: frame byte sequencer and result register.
    mrfb_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_q_cmd            (q_cmd),
        .o_q_pop            (q_pop),
        .i_slave_address    (r_slave_address),
        .i_function_code    (r_function_code),
        .i_register_address (r_register_address),
        .i_pop              (pop),
        .o_valid            (out_valid),
        .o_result           (o_result),
        .o_status           (back_status)
    );

    assign empty = !out_valid;

    // The queue can only fill up behind a busy back.
    `MRFB_ASSERT_IMPL(a_full_busy, q_full, back_status.busy, "queue full while back idle")
    // The sequencer never runs past the CRC high byte.
    `MRFB_ASSERT_IMPL(a_step_range, back_status.busy,
        back_status.step <= mrfb_pkg::STEP_CRCH, "back step out of range")
    // A broadcast frame end is always followed by a header, so the back stays busy.
    `MRFB_ASSERT_IMPL(a_bc_then_header, !empty && o_result.frame_end && !o_result.run_last,
        back_status.busy, "broadcast frame ended without a header following")

endmodule
